### sv/last_bytes_history_buffer_assert.svh
// ----------------------------------------------------------------------------
// last_bytes_history_buffer_assert.svh
// Assertion macros used by the checker file of the history buffer.
// ----------------------------------------------------------------------------
`ifndef LAST_BYTES_HISTORY_BUFFER_ASSERT_SVH
`define LAST_BYTES_HISTORY_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBHB_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBHB_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

### sv/lbhb_pkg.sv
// ----------------------------------------------------------------------------
// lbhb_pkg
// Types and constants shared by the history buffer modules.
// ----------------------------------------------------------------------------
package lbhb_pkg;

    // Ring size and the widths that follow from it.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    // Capacity after reset.
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // Action codes.
    localparam logic [1:0] ACT_APPEND  = 2'd0;
    localparam logic [1:0] ACT_DISCARD = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    // Request beat.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic [8:0] amount;
        logic [7:0] read_offset;
    } lbhb_req_t;

    // Response beat.
    typedef struct packed {
        logic [8:0] fill_level;
        logic [7:0] read_byte;
    } lbhb_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic step;     // a request beat is taken this cycle
        logic rd_done;  // the store read data is valid this cycle
    } lbhb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;  // the pending request is a read
    } lbhb_sts_t;

endpackage

### sv/lbhb_ram.sv
// ----------------------------------------------------------------------------
// lbhb_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lbhb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lbhb_ctrl.sv
// ----------------------------------------------------------------------------
// lbhb_ctrl
// Controller: request and response handshakes, and the wait on a store read.
// ----------------------------------------------------------------------------
module lbhb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  lbhb_pkg::lbhb_sts_t sts,
    output lbhb_pkg::lbhb_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic accept;

    // A new beat is taken when the response register is free by the next edge.
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    assign cmd.step    = accept;
    assign cmd.rd_done = (state_reg == S_RD);

    // Next state and response valid.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_read)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### sv/lbhb_dp.sv
// ----------------------------------------------------------------------------
// lbhb_dp
// Datapath: capacity, ring pointer, fill count, byte store and response.
// ----------------------------------------------------------------------------
module lbhb_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  lbhb_pkg::lbhb_cmd_t cmd,
    output lbhb_pkg::lbhb_sts_t sts,
    input  lbhb_pkg::lbhb_req_t req,
    input  logic                cfg_we,
    input  logic [8:0]          cfg_data,
    output lbhb_pkg::lbhb_rsp_t rsp
);

    logic [lbhb_pkg::CNT_W-1:0]  capacity_reg;
    logic [lbhb_pkg::ADDR_W-1:0] oldest_reg;
    logic [lbhb_pkg::ADDR_W-1:0] oldest_next;
    logic [lbhb_pkg::CNT_W-1:0]  held_reg;
    logic [lbhb_pkg::CNT_W-1:0]  held_next;
    logic [lbhb_pkg::CNT_W-1:0]  eff_cap;
    logic [lbhb_pkg::CNT_W-1:0]  held_c;
    logic                        full;
    logic [lbhb_pkg::ADDR_W-1:0] slot;
    logic [lbhb_pkg::ADDR_W-1:0] raddr;
    logic                        hit;
    logic                        hit_reg;
    logic                        we;
    logic                        re;
    logic [7:0]                  ram_q;
    lbhb_pkg::lbhb_rsp_t         rsp_reg;

    assign sts.is_read = (req.action == lbhb_pkg::ACT_READ);

    // Capacity in use: zero acts as one, anything above the ring acts as the ring.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = lbhb_pkg::CNT_W'(1);
        end
        else if (capacity_reg > lbhb_pkg::CNT_W'(lbhb_pkg::DEPTH))
        begin
            eff_cap = lbhb_pkg::CNT_W'(lbhb_pkg::DEPTH);
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    assign held_c = (held_reg > eff_cap) ? eff_cap : held_reg;
    assign full   = (held_c >= eff_cap);

    // Ring addresses wrap by dropping the carry.
    assign slot  = full ? (oldest_reg + eff_cap[lbhb_pkg::ADDR_W-1:0])
                        : (oldest_reg + held_c[lbhb_pkg::ADDR_W-1:0]);
    assign raddr = oldest_reg + req.read_offset;
    assign hit   = ({1'b0, req.read_offset} < held_c);

    // Pointer and count update for the action at hand.
    always_comb
    begin
        oldest_next = oldest_reg;
        held_next   = held_c;
        case (req.action)
            lbhb_pkg::ACT_APPEND:
            begin
                if (full)
                begin
                    oldest_next = oldest_reg + lbhb_pkg::ADDR_W'(1);
                end
                else
                begin
                    held_next = held_c + lbhb_pkg::CNT_W'(1);
                end
            end
            lbhb_pkg::ACT_DISCARD:
            begin
                if (req.amount >= held_c)
                begin
                    oldest_next = '0;
                    held_next   = '0;
                end
                else
                begin
                    oldest_next = oldest_reg + req.amount[lbhb_pkg::ADDR_W-1:0];
                    held_next   = held_c - req.amount;
                end
            end
            lbhb_pkg::ACT_READ:
            begin
                held_next = held_c;
            end
            lbhb_pkg::ACT_CLEAR:
            begin
                oldest_next = '0;
                held_next   = '0;
            end
            default:
            begin
                held_next = held_c;
            end
        endcase
    end

    // Capacity register, pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lbhb_pkg::CAP_RESET;
            oldest_reg   <= '0;
            held_reg     <= '0;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
            oldest_reg   <= '0;
            held_reg     <= '0;
        end
        else if (cmd.step)
        begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
        end
    end

    assign we = cmd.step && (req.action == lbhb_pkg::ACT_APPEND);
    assign re = cmd.step && sts.is_read;

    lbhb_ram #(
        .WIDTH (8),
        .DEPTH (lbhb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot),
        .wdata (req.data_byte),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Response payload: fill level at the step, read byte once the store answers.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rsp_reg.fill_level <= held_next;
            rsp_reg.read_byte  <= 8'h00;
            hit_reg            <= re && hit;
        end
        else if (cmd.rd_done)
        begin
            rsp_reg.read_byte <= hit_reg ? ram_q : 8'h00;
        end
    end

    assign rsp = rsp_reg;

endmodule

### sv/last_bytes_history_buffer.sv
// ----------------------------------------------------------------------------
// last_bytes_history_buffer
// Keeps the most recent bytes written, up to a programmed capacity.
// Request channel (req_valid/req_ready, req): one beat is one action: append,
// discard oldest bytes, read at an offset from the oldest byte, or clear.
// Response channel (rsp_valid/rsp_ready, rsp): one beat per request with the
// fill level after the action and the byte read (zero unless a read hits).
// Config channel (cfg_valid/cfg_ready, cfg_data): writes the capacity and
// empties the buffer; write it only while no request is in flight.
// Append, discard and clear answer in the cycle after the request beat; a read
// answers once the store's registered read port has delivered the byte.
// Throughput: one request per cycle while responses are taken; a read holds off the next request until it answers.
// A stalled response holds the next request off only until it is taken.
// Reset empties the buffer and sets the capacity to 256; store contents stay.
// ----------------------------------------------------------------------------
module last_bytes_history_buffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lbhb_pkg::lbhb_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lbhb_pkg::lbhb_rsp_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [8:0]          cfg_data
);

    lbhb_pkg::lbhb_cmd_t cmd;
    lbhb_pkg::lbhb_sts_t sts;

    // The capacity register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    lbhb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lbhb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule

### sv/lbhb_checker.sv
// ----------------------------------------------------------------------------
// lbhb_checker
// Port-level checks of the history buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "last_bytes_history_buffer_assert.svh"

module lbhb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input lbhb_pkg::lbhb_req_t req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input lbhb_pkg::lbhb_rsp_t rsp
);

    logic req_beat;
    logic rsp_stall;
    logic fill_ok;
    logic rsp_empty;
    logic fast_beat;
    logic clear_beat;

    // Shorthands for the handshakes and the response fields.
    assign req_beat   = req_valid && req_ready;
    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign fill_ok    = (rsp.fill_level <= 9'(lbhb_pkg::DEPTH));
    assign rsp_empty  = rsp_valid && (rsp.fill_level == 9'd0);
    assign fast_beat  = req_beat && (req.action != lbhb_pkg::ACT_READ);
    assign clear_beat = req_beat && (req.action == lbhb_pkg::ACT_CLEAR);

    // A stalled response beat stays put.
    `LBHB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "beat moved in stall")

    // The fill level never exceeds the ring size.
    `LBHB_ASSERT_NOW(a_fill_max, rsp_valid, fill_ok, "fill level above ring size")

    // An empty buffer reads back zero.
    `LBHB_ASSERT_NOW(a_empty_zero, rsp_empty, rsp.read_byte == 8'h00, "nonzero byte when empty")

    // Any action other than a read answers in the next cycle.
    `LBHB_ASSERT_NEXT(a_fast_rsp, fast_beat, rsp_valid, "no response one cycle after a beat")

    // A clear leaves the buffer empty.
    `LBHB_ASSERT_NEXT(a_clear_empty, clear_beat, rsp.fill_level == 9'd0, "not empty after clear")

endmodule

bind last_bytes_history_buffer lbhb_checker u_lbhb_checker (.*);

### verif/tb_last_bytes_history_buffer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_last_bytes_history_buffer
// Self-checking bench for the overwriting history buffer. A short table of
// actions runs first. Random phases follow, each under its own capacity.
// Every response beat is compared with its typed table entry or else with a bit-level prediction of the ring.
// ----------------------------------------------------------------------------
module tb_last_bytes_history_buffer;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_ROWS   = 24;
    localparam int PHASES      = 8;

    // Capacity and request count per random phase. A zero capacity in the
    // seventh slot is replaced by a random one at run time.
    localparam logic [8:0] PHASE_CAPS [PHASES] =
        '{9'd1, 9'd0, 9'd2, 9'd511, 9'd5, 9'd255, 9'd0, 9'd256};
    localparam int PHASE_ITEMS [PHASES] = '{120, 60, 100, 420, 110, 400, 160, 180};

    // One row of the directed table; the response is only typed in when known.
    typedef struct {
        lbhb_pkg::lbhb_req_t beat;
        logic                known;
        lbhb_pkg::lbhb_rsp_t rsp;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    lbhb_pkg::lbhb_req_t req;
    logic                rsp_valid;
    logic                rsp_ready;
    lbhb_pkg::lbhb_rsp_t rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [8:0]          cfg_data;

    // Typed expectation of the request currently on the bus.
    logic                plan_known;
    lbhb_pkg::lbhb_rsp_t plan_rsp;

    // Idle and stall chances of the current phase, in percent.
    int req_gap_pct;
    int rsp_stall_pct;

    int mismatch_count = 0;
    int cycle_count = 0;

    // Prediction state of the ring.
    logic [7:0]                  ring_model [lbhb_pkg::DEPTH];
    logic [lbhb_pkg::ADDR_W-1:0] oldest_model = '0;
    logic [lbhb_pkg::CNT_W-1:0]  fill_model = '0;
    logic [lbhb_pkg::CNT_W-1:0]  cap_model = lbhb_pkg::CAP_RESET;

    lbhb_pkg::lbhb_rsp_t due_responses [$];
    plan_row_t           history_plan [PLAN_ROWS];

    last_bytes_history_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of 8 ns.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard limit on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatch_count++;
        end
    endtask

    // Applies one action to the predicted ring and returns its response.
    function automatic lbhb_pkg::lbhb_rsp_t step_history(input lbhb_pkg::lbhb_req_t r);
        lbhb_pkg::lbhb_rsp_t        res;
        logic [lbhb_pkg::CNT_W-1:0] limit;
        begin
            res = '0;
            limit = cap_model;
            if (limit == '0)
                limit = lbhb_pkg::CNT_W'(1);
            if (limit > lbhb_pkg::CNT_W'(lbhb_pkg::DEPTH))
                limit = lbhb_pkg::CNT_W'(lbhb_pkg::DEPTH);
            if (fill_model > limit)
                fill_model = limit;
            case (r.action)
                lbhb_pkg::ACT_APPEND:
                begin
                    if (fill_model >= limit)
                    begin
                        // Full: the new byte takes the place of the oldest one.
                        ring_model[lbhb_pkg::ADDR_W'(oldest_model + limit)] = r.data_byte;
                        oldest_model = oldest_model + 1'b1;
                    end
                    else
                    begin
                        ring_model[lbhb_pkg::ADDR_W'(oldest_model + fill_model)] =
                            r.data_byte;
                        fill_model = fill_model + 1'b1;
                    end
                end
                lbhb_pkg::ACT_DISCARD:
                begin
                    if (r.amount >= fill_model)
                    begin
                        fill_model = '0;
                        oldest_model = '0;
                    end
                    else
                    begin
                        oldest_model = lbhb_pkg::ADDR_W'(oldest_model + r.amount);
                        fill_model = fill_model - r.amount;
                    end
                end
                lbhb_pkg::ACT_READ:
                begin
                    if ({1'b0, r.read_offset} < fill_model)
                        res.read_byte =
                            ring_model[lbhb_pkg::ADDR_W'(oldest_model + r.read_offset)];
                end
                default:
                begin
                    fill_model = '0;
                    oldest_model = '0;
                end
            endcase
            res.fill_level = fill_model;
            return res;
        end
    endfunction

    // Builds one row of the directed table.
    function automatic plan_row_t plan_row(input logic [1:0] action, input logic [7:0] data,
                                           input logic [8:0] amount, input logic [7:0] offset,
                                           input logic known, input logic [8:0] fill,
                                           input logic [7:0] rbyte);
        plan_row_t row;
        begin
            row.beat.action = action;
            row.beat.data_byte = data;
            row.beat.amount = amount;
            row.beat.read_offset = offset;
            row.known = known;
            row.rsp.fill_level = fill;
            row.rsp.read_byte = rbyte;
            return row;
        end
    endfunction

    // Checks response beats, then predicts accepted request beats and follows
    // capacity writes.
    always @(posedge clk)
    begin : monitor
        lbhb_pkg::lbhb_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_responses.size() == 0)
                begin
                    report_mismatch($sformatf("response beat with none pending, fill %0d byte %0d",
                                              rsp.fill_level, rsp.read_byte));
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp.fill_level !== want.fill_level)
                        report_mismatch($sformatf("fill_level %0d, expected %0d",
                                                  rsp.fill_level, want.fill_level));
                    if (rsp.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte %0d, expected %0d",
                                                  rsp.read_byte, want.read_byte));
                end
            end
            if (req_valid && req_ready)
            begin
                want = step_history(req);
                if (plan_known)
                    want = plan_rsp;
                due_responses.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_model = cfg_data;
                fill_model = '0;
                oldest_model = '0;
            end
        end
    end

    // Response side: rsp_ready drops in random stall bursts.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < rsp_stall_pct)
            begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ready = 1'b1;
            end
        end
    end

    // Drives one request beat, possibly after an idle burst, and returns at the
    // falling edge after it was taken.
    task automatic drive_request(input lbhb_pkg::lbhb_req_t beat, input logic known,
                                 input lbhb_pkg::lbhb_rsp_t known_rsp);
        begin
            if ($urandom_range(0, 99) < req_gap_pct)
            begin
                req_valid = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            req = beat;
            plan_known = known;
            plan_rsp = known_rsp;
            req_valid = 1'b1;
            @(posedge clk);
            while (!req_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Waits until every response has come back.
    task automatic drain_responses();
        begin
            req_valid = 1'b0;
            while (due_responses.size() != 0)
                @(negedge clk);
            repeat (3) @(negedge clk);
        end
    endtask

    // Writes the capacity while no request is in flight.
    task automatic write_capacity(input logic [8:0] value);
        begin
            drain_responses();
            cfg_data = value;
            cfg_valid = 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // Main sequence: reset, directed table, then the random phases.
    initial
    begin
        lbhb_pkg::lbhb_req_t beat;
        logic [8:0]          cap;
        int                  pick;
        logic                deep;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        plan_known = 1'b0;
        plan_rsp = '0;
        req_gap_pct = 15;
        rsp_stall_pct = 15;

        history_plan = '{
            // Empty buffer after reset.
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_DISCARD, 8'hFF, 9'd0,   8'hFF,  1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_DISCARD, 8'h00, 9'd256, 8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_CLEAR,   8'hFF, 9'd511, 8'hFF,  1'b1, 9'd0, 8'h00),
            // Fill with byte extremes and read the first and the last back.
            plan_row(lbhb_pkg::ACT_APPEND,  8'hFF, 9'd0,   8'd0,   1'b1, 9'd1, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'h00, 9'd0,   8'd0,   1'b1, 9'd2, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'hA5, 9'd0,   8'd0,   1'b1, 9'd3, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd0,   1'b1, 9'd3, 8'hFF),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd2,   1'b1, 9'd3, 8'hA5),
            // Reads at and beyond the fill level return zero.
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd3,   1'b1, 9'd3, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd255, 1'b1, 9'd3, 8'h00),
            // Partial and zero discards.
            plan_row(lbhb_pkg::ACT_DISCARD, 8'h00, 9'd1,   8'd0,   1'b1, 9'd2, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd0,   1'b1, 9'd2, 8'h00),
            plan_row(lbhb_pkg::ACT_DISCARD, 8'h00, 9'd0,   8'd0,   1'b1, 9'd2, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'h5A, 9'd0,   8'd0,   1'b0, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd2,   1'b0, 9'd0, 8'h00),
            // Discard of more than held, then reuse from the start of the ring.
            plan_row(lbhb_pkg::ACT_DISCARD, 8'h00, 9'd256, 8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'h3C, 9'd0,   8'd0,   1'b1, 9'd1, 8'h00),
            plan_row(lbhb_pkg::ACT_CLEAR,   8'h00, 9'd0,   8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'h81, 9'd0,   8'd0,   1'b1, 9'd1, 8'h00),
            plan_row(lbhb_pkg::ACT_DISCARD, 8'h00, 9'd2,   8'd0,   1'b1, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_APPEND,  8'h7E, 9'd0,   8'd0,   1'b0, 9'd0, 8'h00),
            plan_row(lbhb_pkg::ACT_READ,    8'h00, 9'd0,   8'd0,   1'b0, 9'd0, 8'h00)
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table under the reset capacity.
        for (int i = 0; i < PLAN_ROWS; i++)
            drive_request(history_plan[i].beat, history_plan[i].known, history_plan[i].rsp);

        // Random phases, each after a capacity write.
        for (int p = 0; p < PHASES; p++)
        begin
            cap = PHASE_CAPS[p];
            if (p == 6)
                cap = 9'($urandom_range(3, 64));
            write_capacity(cap);
            deep = (cap >= 9'd128);
            if (p == PHASES - 1)
            begin
                req_gap_pct = 0;
                rsp_stall_pct = 0;
            end
            else
            begin
                req_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
                rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 12;
            end

            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                // Unused fields carry random noise.
                beat.data_byte = 8'($urandom);
                beat.amount = 9'($urandom_range(0, 256));
                beat.read_offset = 8'($urandom);
                pick = $urandom_range(0, 99);
                if (deep)
                begin
                    // Mostly appends so that the ring fills and wraps.
                    if (pick < 78)
                        beat.action = lbhb_pkg::ACT_APPEND;
                    else if (pick < 96)
                        beat.action = lbhb_pkg::ACT_READ;
                    else
                        beat.action = lbhb_pkg::ACT_DISCARD;
                end
                else
                begin
                    if (pick < 48)
                        beat.action = lbhb_pkg::ACT_APPEND;
                    else if (pick < 78)
                        beat.action = lbhb_pkg::ACT_READ;
                    else if (pick < 94)
                        beat.action = lbhb_pkg::ACT_DISCARD;
                    else
                        beat.action = lbhb_pkg::ACT_CLEAR;
                end

                if (beat.action == lbhb_pkg::ACT_DISCARD)
                begin
                    pick = $urandom_range(0, 9);
                    if (deep || pick < 6)
                        beat.amount = 9'($urandom_range(0, 3));
                    else if (pick == 6)
                        beat.amount = fill_model;
                    else if (pick == 7 && fill_model != '0)
                        beat.amount = fill_model - 1'b1;
                    else if (pick == 8)
                        beat.amount = 9'd256;
                end

                // Reads mostly land inside the held bytes.
                if (beat.action == lbhb_pkg::ACT_READ && fill_model != '0
                    && $urandom_range(0, 3) != 0)
                    beat.read_offset = 8'($urandom_range(0, fill_model - 1));

                drive_request(beat, 1'b0, '0);
            end
        end

        drain_responses();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
